// ===== rtl/core/bal_pkg.sv =====
// Package for the bounded array list: command codes, sizing constants and the
// first-match priority encoder used by the top level.
// No dependencies.
package bal_pkg;

	localparam int MAX_CAP   = 256;
	localparam int MAX_IDX_W = $clog2(MAX_CAP);
	localparam int DEF_CAP   = 32;

	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int VAL_W   = 32;
	localparam int IDXO_W  = 5;
	localparam int COUNT_W = 6;

	localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd5;

	typedef struct packed {
		logic put;
		logic up;
		logic dn;
		logic look;
	} cell_ctl_t;

	// lowest set bit, as a log-depth tree of pairwise picks
	function automatic logic [MAX_IDX_W:0] first_set(input logic [MAX_CAP-1:0] v);
		logic [MAX_CAP-1:0]   f;
		logic [MAX_IDX_W-1:0] ix [MAX_CAP];
		f = v;
		for (int j = 0; j < MAX_CAP; j++) begin
			ix[j] = MAX_IDX_W'(j);
		end
		for (int l = 0; l < MAX_IDX_W; l++) begin
			for (int j = 0; j < MAX_CAP; j += (2 << l)) begin
				if (!f[j]) begin
					ix[j] = ix[j + (1 << l)];
				end
				f[j] = f[j] | f[j + (1 << l)];
			end
		end
		return {f[0], ix[0]};
	endfunction

endpackage

// ===== rtl/core/bal_cell.sv =====
// One list slot: holds an entry, takes a new value or a neighbor's value on
// a shift, and flags a search match. Depends on bal_pkg.
module bal_cell
	import bal_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CMP_W = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic [CMP_W-1:0]        where,
	input  logic [CMP_W-1:0]        sel,
	input  logic [CMP_W-1:0]        fill,
	input  logic signed [VAL_W-1:0] value,
	input  logic signed [VAL_W-1:0] left,
	input  logic signed [VAL_W-1:0] right,
	output logic signed [VAL_W-1:0] entry,
	output logic signed [VAL_W-1:0] pick,
	output logic                    match
);

	localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

	logic signed [VAL_W-1:0] entry_q;
	logic                    match_q;
	logic                    at_where;
	logic                    past_where;

	assign at_where   = (MY_IDX == where);
	assign past_where = (MY_IDX >= where);

	always_ff @(posedge clk) begin
		if (ctl.put && at_where) begin
			entry_q <= value;
		end else if ((ctl.up && past_where) || (ctl.dn && past_where)) begin
			entry_q <= ctl.up ? left : right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.look) begin
			match_q <= (entry_q == value) && (MY_IDX < fill);
		end
	end

	assign entry = entry_q;
	assign pick  = (MY_IDX == sel) ? entry_q : '0;
	assign match = match_q;

endmodule

// ===== rtl/core/bounded_array_list_unit.sv =====
// Top level of the bounded array list: a row of list cells, command decode,
// count register and result register. Depends on bal_pkg and bal_cell.
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid / in_stall | cmd, position, value
//  out     | out of    | out_valid/out_stall | ok, data, found_index, count,
//          |           |                     | full_res, empty_res
//
// The cells shift and compare in the cycle the beat is taken, then the
// first-match encoder over the cell match flags fills the result register
// in the next cycle.
// A new beat is taken once the previous result has left or leaves that cycle.
// Reset clears the count and all handshake state; entries are not cleared.
module bounded_array_list_unit
	import bal_pkg::*;
#(
	parameter int CAPACITY = DEF_CAP
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        cmd,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    ok,
	output logic signed [VAL_W-1:0] data,
	output logic [IDXO_W-1:0]       found_index,
	output logic [COUNT_W-1:0]      count,
	output logic                    full_res,
	output logic                    empty_res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

	logic [CNT_W-1:0]        count_q;
	logic                    busy_q;
	logic                    out_valid_q;
	logic                    ok_s1;
	logic                    search_s1;
	logic signed [VAL_W-1:0] data_s1;
	logic                    ok_q;
	logic signed [VAL_W-1:0] data_q;
	logic [IDXO_W-1:0]       idx_q;

	logic                    take;
	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [CMP_W-1:0]        where;
	logic [CMP_W-1:0]        sel;
	logic                    op_ok;
	logic [CNT_W-1:0]        count_d;
	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] ent [CAPACITY];
	logic signed [VAL_W-1:0] pick [CAPACITY];
	logic [CAPACITY-1:0]     match;
	logic signed [VAL_W-1:0] pick_or;
	logic [MAX_IDX_W:0]      first;

	assign take     = in_valid && !in_stall;
	assign in_stall = busy_q || (out_valid_q && out_stall);
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);

	always_comb begin
		ctl     = '0;
		op_ok   = 1'b0;
		where   = pos_x;
		sel     = pos_x;
		count_d = count_q;
		case (cmd)
			CMD_APPEND: begin
				op_ok   = (cnt_x < CAP_C);
				where   = cnt_x;
				ctl.put = op_ok;
				count_d = op_ok ? count_q + 1'b1 : count_q;
			end
			CMD_INSERT: begin
				op_ok   = (cnt_x < CAP_C);
				where   = (pos_x >= cnt_x) ? cnt_x : pos_x;
				ctl.put = op_ok;
				ctl.up  = op_ok;
				count_d = op_ok ? count_q + 1'b1 : count_q;
			end
			CMD_REMOVE: begin
				op_ok   = (pos_x < cnt_x);
				ctl.dn  = op_ok;
				count_d = op_ok ? count_q - 1'b1 : count_q;
			end
			CMD_POP: begin
				op_ok   = (count_q != '0);
				sel     = cnt_x - 1'b1;
				count_d = op_ok ? count_q - 1'b1 : count_q;
			end
			CMD_READ: begin
				op_ok = (pos_x < cnt_x);
			end
			CMD_SEARCH: begin
				ctl.look = 1'b1;
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
		if (!take) begin
			ctl = '0;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bal_cell #(
			.IDX   (i),
			.CMP_W (CMP_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.where  (where),
			.sel    (sel),
			.fill   (cnt_x),
			.value  (value),
			.left   ((i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1]),
			.right  ((i == CAPACITY - 1) ? ent[i] : ent[(i == CAPACITY - 1) ? i : i + 1]),
			.entry  (ent[i]),
			.pick   (pick[i]),
			.match  (match[i])
		);
	end

	always_comb begin
		pick_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_or = pick_or | pick[i];
		end
	end

	assign first = first_set(MAX_CAP'(match));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q <= count_d;
			end
			busy_q <= take;
			if (busy_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ok_s1     <= op_ok;
			search_s1 <= (cmd == CMD_SEARCH);
			data_s1   <= (op_ok && (cmd inside {CMD_REMOVE, CMD_POP, CMD_READ}))
				? pick_or : '0;
		end
		if (busy_q) begin
			ok_q   <= search_s1 ? first[MAX_IDX_W] : ok_s1;
			data_q <= data_s1;
			idx_q  <= (search_s1 && first[MAX_IDX_W]) ? IDXO_W'(first[MAX_IDX_W-1:0]) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign data        = data_q;
	assign found_index = idx_q;
	assign count       = COUNT_W'(count_q);
	assign full_res    = (cnt_x == CAP_C);
	assign empty_res   = (count_q == '0);

	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !out_valid_q)
		else $error("result still pending while a command is in flight");

	a_take_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ##1 out_valid_q)
		else $error("accepted beat produced no result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CAP_C)
		else $error("entry count above capacity");

endmodule
